// File: design/mdp_pkg.sv
// ---------------------------------------------------------------------------
// Mip downsampler package
// Shared sizes, codes and transfer types of the 2x2 mip downsampler.
// ---------------------------------------------------------------------------
package mdp_pkg;

  // Largest supported source level.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Configuration port.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;

  // Pixel format: four 8-bit channels, red in the low byte.
  localparam int CH_W  = 8;
  localparam int PIX_W = 4 * CH_W;

  // Source counters and destination sizes.
  localparam int SCOL_W = $clog2(MAX_WIDTH);
  localparam int SROW_W = $clog2(MAX_HEIGHT);
  localparam int DSZ_W  = SCOL_W;
  localparam int HSZ_W  = SROW_W;

  // Destination coordinates as seen on the output channel.
  localparam int DCOL_W = 10;
  localparam int DROW_W = 10;

  // Row stores.
  localparam int BANK_DEPTH = MAX_WIDTH / 2;
  localparam int DEST_DEPTH = MAX_WIDTH / 2;

  // Bottom padding position, up to three padded rows.
  localparam int PAD_W = DSZ_W + 1;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input item kinds.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  // Job kinds carried through the queue.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_PAD   = 1'b1
  } op_t;

  // Level geometry derived from the configuration registers.
  typedef struct packed {
    logic [SCOL_W:0]   w;
    logic [SROW_W:0]   h;
    logic              w_one;
    logic              h_one;
    logic [DSZ_W-1:0]  dw;
    logic [DSZ_W-1:0]  pw;
    logic [HSZ_W-1:0]  dh;
    logic [HSZ_W-1:0]  ph;
  } geom_t;

  // One destination job: a run of columns col..end_col on one row.
  typedef struct packed {
    op_t               op;
    logic [PIX_W-1:0]  pix;
    logic [DCOL_W-1:0] col;
    logic [DCOL_W-1:0] end_col;
    logic [DROW_W-1:0] row;
    logic              last_end;
    logic [DCOL_W-1:0] idx;
  } job_t;

endpackage

// File: design/mdp_in_if.sv
// ---------------------------------------------------------------------------
// Mip downsampler input channel
// Valid/ready channel carrying source pixels and flush ticks.
// ---------------------------------------------------------------------------
interface mdp_in_if import mdp_pkg::*; ();

  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;

  modport source (
    output valid, kind, in_red, in_green, in_blue, in_alpha,
    input  ready
  );

  modport sink (
    input  valid, kind, in_red, in_green, in_blue, in_alpha,
    output ready
  );

endinterface

// File: design/mdp_out_if.sv
// ---------------------------------------------------------------------------
// Mip downsampler output channel
// Valid/ready channel carrying destination pixels and their position.
// ---------------------------------------------------------------------------
interface mdp_out_if import mdp_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic [CH_W-1:0]   out_alpha;
  logic [DCOL_W-1:0] out_col;
  logic [DROW_W-1:0] out_row;
  logic              last;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, out_col, out_row, last,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, out_col, out_row, last,
    output ready
  );

endinterface

// File: design/mdp_front.sv
// ---------------------------------------------------------------------------
// Mip downsampler front end
// Accepts input transactions, tracks the source position, keeps the even
// source row and turns each transaction into at most one destination job.
// ---------------------------------------------------------------------------
module mdp_front import mdp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  geom_t  geom,
  mdp_in_if.sink in_s,
  output logic   enq_valid,
  output job_t   enq_job,
  input  logic   enq_ready
);

  typedef struct packed {
    op_t               op;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  p10;
    logic              bypass;
    logic              w_one;
    logic [DCOL_W-1:0] col;
    logic [DCOL_W-1:0] end_col;
    logic [DROW_W-1:0] row;
    logic              last_end;
    logic [DCOL_W-1:0] idx;
  } cmd_t;

  // Rounded mean of four pixels, channel by channel.
  function automatic logic [PIX_W-1:0] mean4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] res;
    logic [CH_W+1:0]  s;
    res = '0;
    for (int k = 0; k < PIX_W / CH_W; k++) begin
      s = (CH_W+2)'(a[k*CH_W +: CH_W]) + (CH_W+2)'(b[k*CH_W +: CH_W]) +
          (CH_W+2)'(c[k*CH_W +: CH_W]) + (CH_W+2)'(d[k*CH_W +: CH_W]) +
          (CH_W+2)'(2);
      res[k*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return res;
  endfunction

  // Position and level state.
  logic [SCOL_W-1:0] src_col_r, src_col_nxt;
  logic [SROW_W-1:0] src_row_r, src_row_nxt;
  logic [PIX_W-1:0]  held_r, held_nxt;
  logic [PAD_W-1:0]  pad_pos_r, pad_pos_nxt;
  logic              src_done_r, src_done_nxt;

  // Handshake.
  logic              in_take;
  logic              pix_take;
  logic [PIX_W-1:0]  in_pix;

  // Derived sizes.
  logic [DSZ_W-1:0]  dw_m1, pw_m1;
  logic [HSZ_W-1:0]  ph_m1;

  // Source pixel classification.
  logic [DCOL_W-1:0] c_half;
  logic [DROW_W-1:0] r_half;
  logic              row_hit, col_hit;
  logic [DCOL_W-1:0] px_x, px_end;
  logic [DROW_W-1:0] px_y;
  logic              px_last;
  logic [SCOL_W:0]   c_inc;
  logic [SROW_W:0]   r_inc;

  // Bottom padding.
  logic [HSZ_W-1:0]  pad_rows_full;
  logic [1:0]        pad_rows;
  logic [PAD_W-1:0]  pw_ext, pw_x2, pad_total, pad_pos_inc, pad_col_full;
  logic [1:0]        pad_q;
  logic [HSZ_W-1:0]  pad_row_full;
  logic [DCOL_W-1:0] pad_col, pad_idx;
  logic              pad_end, pad_last;

  // Second stage.
  cmd_t              cmd_in;
  logic              cmd_load;
  cmd_t              s2_r;
  logic              s2_valid_r, s2_valid_nxt;
  logic [PIX_W-1:0]  rd_even_r, rd_odd_r;
  logic [PIX_W-1:0]  s00, s01, avg;

  // Even source row, split by column parity so a pair reads at one address.
  logic [PIX_W-1:0]  bank_even [BANK_DEPTH];
  logic [PIX_W-1:0]  bank_odd  [BANK_DEPTH];

  // Input handshake.
  assign in_s.ready = !s2_valid_r || enq_ready;
  assign in_take    = in_s.valid && in_s.ready;
  assign pix_take   = in_take && (in_s.kind == KIND_PIXEL) && !src_done_r;
  assign in_pix     = {in_s.in_alpha, in_s.in_blue, in_s.in_green, in_s.in_red};

  assign dw_m1 = geom.dw - DSZ_W'(1);
  assign pw_m1 = geom.pw - DSZ_W'(1);
  assign ph_m1 = geom.ph - HSZ_W'(1);

  // Where the current source pixel lands in the destination.
  always_comb begin
    c_half  = src_col_r[SCOL_W-1:1];
    r_half  = src_row_r[SROW_W-1:1];
    row_hit = geom.h_one ? (src_row_r == '0)
                         : (src_row_r[0] && (HSZ_W'(r_half) < geom.dh));
    col_hit = geom.w_one ? (src_col_r == '0)
                         : (src_col_r[0] && (DSZ_W'(c_half) < geom.dw));
    px_x    = geom.w_one ? '0 : c_half;
    px_y    = geom.h_one ? '0 : r_half;
    px_end  = (DSZ_W'(px_x) == dw_m1) ? pw_m1[DCOL_W-1:0] : px_x;
    px_last = (HSZ_W'(px_y) == ph_m1) && (DSZ_W'(px_end) == pw_m1);
    c_inc   = {1'b0, src_col_r} + (SCOL_W+1)'(1);
    r_inc   = {1'b0, src_row_r} + (SROW_W+1)'(1);
  end

  // Bottom padding position split into row and column (at most three rows).
  always_comb begin
    pad_rows_full = geom.ph - geom.dh;
    pad_rows      = pad_rows_full[1:0];
    pw_ext        = PAD_W'(geom.pw);
    pw_x2         = pw_ext << 1;
    pad_total     = (pad_rows[1] ? pw_x2 : '0) + (pad_rows[0] ? pw_ext : '0);
    pad_end       = (pad_pos_r >= pad_total);
    pad_pos_inc   = pad_pos_r + PAD_W'(1);
    pad_last      = (pad_pos_inc == pad_total);
    if (pad_pos_r < pw_ext) begin
      pad_q        = 2'd0;
      pad_col_full = pad_pos_r;
    end else if (pad_pos_r < pw_x2) begin
      pad_q        = 2'd1;
      pad_col_full = pad_pos_r - pw_ext;
    end else begin
      pad_q        = 2'd2;
      pad_col_full = pad_pos_r - pw_x2;
    end
    pad_col      = pad_col_full[DCOL_W-1:0];
    pad_row_full = geom.dh + HSZ_W'(pad_q);
    pad_idx      = (DSZ_W'(pad_col) < geom.dw) ? pad_col : dw_m1[DCOL_W-1:0];
  end

  // Next state and the job command for the accepted transaction.
  always_comb begin
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    held_nxt     = held_r;
    pad_pos_nxt  = pad_pos_r;
    src_done_nxt = src_done_r;
    cmd_load     = 1'b0;
    cmd_in       = '0;
    s2_valid_nxt = s2_valid_r && !enq_ready;

    if (in_take) begin
      if (in_s.kind == KIND_FLUSH) begin
        if (src_done_r) begin
          if (pad_end) begin
            src_done_nxt = 1'b0;
            pad_pos_nxt  = '0;
          end else begin
            cmd_load        = 1'b1;
            cmd_in.op       = OP_PAD;
            cmd_in.col      = pad_col;
            cmd_in.end_col  = pad_col;
            cmd_in.row      = pad_row_full[DROW_W-1:0];
            cmd_in.last_end = pad_last;
            cmd_in.idx      = pad_idx;
            pad_pos_nxt     = pad_pos_inc;
            if (pad_last) begin
              src_done_nxt = 1'b0;
              pad_pos_nxt  = '0;
            end
          end
        end
      end else if (!src_done_r) begin
        held_nxt = in_pix;
        if (row_hit && col_hit) begin
          cmd_load        = 1'b1;
          cmd_in.op       = OP_PIXEL;
          cmd_in.pix      = in_pix;
          cmd_in.p10      = geom.w_one ? in_pix : held_r;
          cmd_in.bypass   = !src_row_r[0];
          cmd_in.w_one    = geom.w_one;
          cmd_in.col      = px_x;
          cmd_in.end_col  = px_end;
          cmd_in.row      = px_y;
          cmd_in.last_end = px_last;
          cmd_in.idx      = px_x;
        end
        // Advance in raster order, wrapping at the level size.
        if (c_inc >= geom.w) begin
          src_col_nxt = '0;
          if (r_inc >= geom.h) begin
            src_row_nxt = '0;
            if (geom.ph > geom.dh) begin
              src_done_nxt = 1'b1;
              pad_pos_nxt  = '0;
            end
          end else begin
            src_row_nxt = r_inc[SROW_W-1:0];
          end
        end else begin
          src_col_nxt = c_inc[SCOL_W-1:0];
        end
      end
    end
    if (cmd_load) begin
      s2_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      held_r     <= '0;
      pad_pos_r  <= '0;
      src_done_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      held_r     <= held_nxt;
      pad_pos_r  <= pad_pos_nxt;
      src_done_r <= src_done_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Second stage command.
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      s2_r <= cmd_in;
    end
  end

  // Even-column bank: written on even rows, read with the pair.
  always_ff @(posedge clk) begin
    if (pix_take && !src_row_r[0] && !src_col_r[0]) begin
      bank_even[c_half] <= in_pix;
    end
    if (pix_take) begin
      rd_even_r <= bank_even[c_half];
    end
  end

  // Odd-column bank.
  always_ff @(posedge clk) begin
    if (pix_take && !src_row_r[0] && src_col_r[0]) begin
      bank_odd[c_half] <= in_pix;
    end
    if (pix_take) begin
      rd_odd_r <= bank_odd[c_half];
    end
  end

  // Upper pair: from the bank on odd rows, from the live row on a single-row level.
  always_comb begin
    if (s2_r.bypass) begin
      s00 = s2_r.p10;
      s01 = s2_r.pix;
    end else begin
      s00 = rd_even_r;
      s01 = s2_r.w_one ? rd_even_r : rd_odd_r;
    end
    avg = mean4(s00, s01, s2_r.p10, s2_r.pix);
  end

  // Job toward the queue.
  assign enq_valid        = s2_valid_r;
  assign enq_job.op       = s2_r.op;
  assign enq_job.pix      = avg;
  assign enq_job.col      = s2_r.col;
  assign enq_job.end_col  = s2_r.end_col;
  assign enq_job.row      = s2_r.row;
  assign enq_job.last_end = s2_r.last_end;
  assign enq_job.idx      = s2_r.idx;

endmodule

// File: design/mdp_fifo.sv
// ---------------------------------------------------------------------------
// Mip downsampler job queue
// Short first-in first-out queue of destination jobs between front and back.
// ---------------------------------------------------------------------------
module mdp_fifo import mdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/mdp_back.sv
// ---------------------------------------------------------------------------
// Mip downsampler back end
// Keeps the latest destination row, fetches bottom padding pixels from it
// and expands each job into one result per column of its run.
// ---------------------------------------------------------------------------
module mdp_back import mdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_ready,
  mdp_out_if.source  out_m
);

  // Destination row store.
  logic [PIX_W-1:0]  dest_mem [DEST_DEPTH];
  logic [PIX_W-1:0]  dest_rd_r;

  // Fetch stage.
  logic              a_valid_r, a_valid_nxt;
  job_t              a_job_r;

  // Output stage.
  logic              b_valid_r, b_valid_nxt;
  logic [PIX_W-1:0]  b_pix_r;
  logic [DCOL_W-1:0] b_col_r, b_end_r;
  logic [DROW_W-1:0] b_row_r;
  logic              b_last_end_r;

  logic              b_at_end, b_take, b_done, b_step, b_free, a_move, pop;

  assign b_at_end  = (b_col_r == b_end_r);
  assign b_take    = b_valid_r && out_m.ready;
  assign b_done    = b_take && b_at_end;
  assign b_step    = b_take && !b_at_end;
  assign b_free    = !b_valid_r || b_done;
  assign a_move    = a_valid_r && b_free;
  assign job_ready = !a_valid_r || a_move;
  assign pop       = job_valid && job_ready;

  // Stage valid flags.
  always_comb begin
    a_valid_nxt = pop ? 1'b1 : (a_valid_r && !a_move);
    b_valid_nxt = a_move ? 1'b1 : (b_valid_r && !b_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Averaged pixels update the row; padding jobs read it.
  always_ff @(posedge clk) begin
    if (pop && (job.op == OP_PIXEL)) begin
      dest_mem[job.col] <= job.pix;
    end
    if (pop) begin
      dest_rd_r <= dest_mem[job.idx];
    end
  end

  // Fetch stage payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      a_job_r <= job;
    end
  end

  // Output register; a run steps through its columns one result at a time.
  always_ff @(posedge clk) begin
    if (a_move) begin
      b_pix_r      <= (a_job_r.op == OP_PAD) ? dest_rd_r : a_job_r.pix;
      b_col_r      <= a_job_r.col;
      b_end_r      <= a_job_r.end_col;
      b_row_r      <= a_job_r.row;
      b_last_end_r <= a_job_r.last_end;
    end else if (b_step) begin
      b_col_r      <= b_col_r + DCOL_W'(1);
    end
  end

  assign out_m.valid     = b_valid_r;
  assign out_m.out_red   = b_pix_r[0*CH_W +: CH_W];
  assign out_m.out_green = b_pix_r[1*CH_W +: CH_W];
  assign out_m.out_blue  = b_pix_r[2*CH_W +: CH_W];
  assign out_m.out_alpha = b_pix_r[3*CH_W +: CH_W];
  assign out_m.out_col   = b_col_r;
  assign out_m.out_row   = b_row_r;
  assign out_m.last      = b_last_end_r && b_at_end;

endmodule

// File: design/mip_downsample_2x2_pad4_core.sv
// ---------------------------------------------------------------------------
// 2x2 mip downsampler with 4-aligned padding
// Box-filters a raster RGBA source level into the next mip level.
// ---------------------------------------------------------------------------
// Usage:
//   in_s carries one transaction per source pixel (kind 0) in raster order,
//   or a flush tick (kind 1) that emits one bottom padding pixel while the
//   padded rows of a finished level are pending.
//   out_m carries destination pixels with their padded column and row; last
//   marks the final pixel of the padded level.
//   cfg_we/cfg_index/cfg_wdata set the source width and height; write them
//   only while no transaction is in flight.
// Timing:
//   One input transaction per cycle while in_s.ready is high. The last pixel
//   of a destination row spawns up to three padding results, one per output
//   cycle while out_m.ready is high, absorbed by a four-entry job queue; a
//   level under four pixels wide can stall the input.
// Reset:
//   Source size returns to 1x1 and all position state clears. The row stores
//   are not cleared; they are always written before they are read.
// Stalls:
//   When out_m.ready is low the output register holds its result, the queue
//   fills, and in_s.ready drops once the queue and front stage are full.
// ---------------------------------------------------------------------------
module mip_downsample_2x2_pad4_core import mdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  mdp_in_if.sink               in_s,
  mdp_out_if.source            out_m
);

  logic [CFG_W-1:0]  cfg_width_r, cfg_width_nxt;
  logic [CFG_W-1:0]  cfg_height_r, cfg_height_nxt;
  geom_t             geom;
  logic              enq_valid, enq_ready;
  job_t              enq_job;
  logic              deq_valid, deq_ready;
  job_t              deq_job;

  // Configuration register writes.
  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  cfg_width_nxt  = cfg_wdata;
        CFG_SRC_HEIGHT: cfg_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(1);
      cfg_height_r <= CFG_W'(1);
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
    end
  end

  // Level geometry: clamp the source size, halve it, align to four.
  always_comb begin
    if (cfg_width_r == '0) begin
      geom.w = (SCOL_W+1)'(1);
    end else if (cfg_width_r > CFG_W'(MAX_WIDTH)) begin
      geom.w = (SCOL_W+1)'(MAX_WIDTH);
    end else begin
      geom.w = (SCOL_W+1)'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      geom.h = (SROW_W+1)'(1);
    end else if (cfg_height_r > CFG_W'(MAX_HEIGHT)) begin
      geom.h = (SROW_W+1)'(MAX_HEIGHT);
    end else begin
      geom.h = (SROW_W+1)'(cfg_height_r);
    end
    geom.w_one = (geom.w == (SCOL_W+1)'(1));
    geom.h_one = (geom.h == (SROW_W+1)'(1));
    geom.dw    = geom.w_one ? DSZ_W'(1) : geom.w[SCOL_W:1];
    geom.dh    = geom.h_one ? HSZ_W'(1) : geom.h[SROW_W:1];
    geom.pw    = (geom.dw + DSZ_W'(3)) & ~DSZ_W'(3);
    geom.ph    = (geom.dh + HSZ_W'(3)) & ~HSZ_W'(3);
  end

  mdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_s      (in_s),
    .enq_valid (enq_valid),
    .enq_job   (enq_job),
    .enq_ready (enq_ready)
  );

  mdp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (enq_valid),
    .push_job   (enq_job),
    .push_ready (enq_ready),
    .pop_valid  (deq_valid),
    .pop_job    (deq_job),
    .pop_ready  (deq_ready)
  );

  mdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (deq_valid),
    .job       (deq_job),
    .job_ready (deq_ready),
    .out_m     (out_m)
  );

endmodule
